[rtl/vdp_pkg.sv]
// vdp_pkg: shared types, codes, constants and base-address helpers for the
// video display processor CPU port; no dependencies
package vdp_pkg;

	localparam int VRAM_DEPTH = 16384;
	localparam int VRAM_AW    = $clog2(VRAM_DEPTH);

	typedef logic [VRAM_AW-1:0] vaddr_t;

	typedef enum logic [2:0] {
		OP_DATA_WR   = 3'd0,
		OP_CTRL_WR   = 3'd1,
		OP_DATA_RD   = 3'd2,
		OP_STATUS_RD = 3'd3,
		OP_TICK      = 3'd4
	} op_t;

	// top two bits of the second control byte
	typedef enum logic [1:0] {
		CMD_RADDR = 2'b00,
		CMD_WADDR = 2'b01,
		CMD_REG   = 2'b10,
		CMD_NONE  = 2'b11
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_TEXT = 2'd0,
		MODE_G1   = 2'd1,
		MODE_G2   = 2'd2,
		MODE_MC   = 2'd3
	} mode_t;

	// control register indexes
	localparam logic [2:0] REG_MODE0  = 3'd0;
	localparam logic [2:0] REG_MODE1  = 3'd1;
	localparam logic [2:0] REG_NAME   = 3'd2;
	localparam logic [2:0] REG_COLOR  = 3'd3;
	localparam logic [2:0] REG_PATT   = 3'd4;
	localparam logic [2:0] REG_SATTR  = 3'd5;
	localparam logic [2:0] REG_SPATT  = 3'd6;
	localparam logic [2:0] REG_COLOUR = 3'd7;

	// mode select codes {reg1[4:3], reg0[3:1]}
	localparam logic [4:0] SEL_TEXT = 5'h10;
	localparam logic [4:0] SEL_G1   = 5'h00;
	localparam logic [4:0] SEL_G2   = 5'h01;
	localparam logic [4:0] SEL_MC   = 5'h08;

	localparam logic [7:0] STATUS_RESET   = 8'h9F;
	localparam logic [7:0] STATUS_RD_KEEP = 8'h5F;
	localparam logic [7:0] TICK_KEEP      = 8'hDF;
	localparam logic [7:0] FRAME_FLAG     = 8'h80;
	localparam logic [7:0] REG1_RESET     = 8'h10;
	localparam int         IRQ_EN_BIT     = 5;
	localparam logic [7:0] SPATT_MASK     = 8'h3F;

	localparam logic [7:0] R2_MASK [4] = '{8'h7F, 8'h0F, 8'h7F, 8'h7F};
	localparam logic [7:0] R3_MASK [4] = '{8'h00, 8'hFF, 8'h80, 8'h00};
	localparam logic [7:0] R4_MASK [4] = '{8'h3F, 8'h07, 8'h3C, 8'h3F};
	localparam logic [7:0] R5_MASK [4] = '{8'h00, 8'h7F, 8'hFF, 8'hFF};

	typedef struct packed {
		logic   we;
		logic   re;
		vaddr_t waddr;
		vaddr_t raddr;
		logic [7:0] wdata;
	} vram_req_t;

	typedef struct packed {
		logic       vram_rd;
		logic [7:0] rd_value;
		logic       irq;
	} step_t;

	typedef struct packed {
		mode_t      mode;
		vaddr_t     name_base;
		vaddr_t     color_base;
		vaddr_t     pattern_base;
		vaddr_t     sattr_base;
		vaddr_t     spattern_base;
		logic [7:0] colour;
	} view_t;

	function automatic vaddr_t name_base_of(logic [7:0] v, mode_t m);
		logic [7:0] t;
		t = v & R2_MASK[m];
		return {t[3:0], 10'b0};
	endfunction

	function automatic vaddr_t color_base_of(logic [7:0] v, mode_t m);
		logic [7:0] t;
		t = v & R3_MASK[m];
		return {t[7:0], 6'b0};
	endfunction

	function automatic vaddr_t pattern_base_of(logic [7:0] v, mode_t m);
		logic [7:0] t;
		t = v & R4_MASK[m];
		return {t[2:0], 11'b0};
	endfunction

	function automatic vaddr_t sattr_base_of(logic [7:0] v, mode_t m);
		logic [7:0] t;
		t = v & R5_MASK[m];
		return {t[6:0], 7'b0};
	endfunction

	function automatic vaddr_t spattern_base_of(logic [7:0] v);
		logic [7:0] t;
		t = v & SPATT_MASK;
		return {t[2:0], 11'b0};
	endfunction

endpackage

[rtl/vdp_if.sv]
// vdp_in_if / vdp_out_if: valid-ready channels for bus operations and results
// depends on vdp_pkg
interface vdp_in_if import vdp_pkg::*;;
	logic       valid;
	logic       ready;
	logic [2:0] op;
	logic [7:0] data;

	modport source (output valid, op, data, input ready);
	modport sink   (input valid, op, data, output ready);
endinterface

interface vdp_out_if import vdp_pkg::*;;
	logic         valid;
	logic         ready;
	logic [7:0]   read_data;
	logic         irq_request;
	logic [1:0]   screen_mode;
	vaddr_t       name_table_base;
	vaddr_t       color_table_base;
	vaddr_t       pattern_table_base;
	vaddr_t       sprite_attr_base;
	vaddr_t       sprite_pattern_base;
	logic [3:0]   fore_color;
	logic [3:0]   back_color;

	modport source (output valid, read_data, irq_request, screen_mode, name_table_base,
		color_table_base, pattern_table_base, sprite_attr_base, sprite_pattern_base,
		fore_color, back_color, input ready);
	modport sink   (input valid, read_data, irq_request, screen_mode, name_table_base,
		color_table_base, pattern_table_base, sprite_attr_base, sprite_pattern_base,
		fore_color, back_color, output ready);
endinterface

[rtl/video_display_processor_port_core.sv]
// video_display_processor_port_core: CPU-side port of a TMS9918-style video
// processor; depends on vdp_pkg, vdp_if, vdp_ctrl and vdp_vram
//
// One bus operation per transaction on the bus channel (data write, control write,
// data read, status read, frame tick) gives exactly one transaction on the result
// channel. Throughput is one operation per clock while the result side keeps up:
// every operation touches the 16K x 8 video memory at most once, through one write
// port and one registered read port, so operations never wait on one another.
// An accepted operation waits in stage 1 and moves into the result register
// once that register is free or being drained. The control latch, address
// counters, status byte and registers update at the accepting edge; a data
// read issues its memory read at that same edge and the byte comes back from
// the memory's output register. A write followed by a read of the same entry
// needs no forwarding, since the write lands at an earlier edge than the one
// at which the read is issued. The mode, table bases and colours shown with a
// result are the values after that operation. Video memory entries that were
// never written read back as whatever the memory holds; there is no clearing
// pass after reset.
module video_display_processor_port_core import vdp_pkg::*; (
	input logic clk,
	input logic arst_n,
	vdp_in_if.sink    bus,
	vdp_out_if.source result
);

	logic      accept;
	logic      advance;
	vram_req_t vram_req;
	step_t     step;
	view_t     view;
	logic [7:0] vram_rdata;

	// stage 1: operation accepted, memory read in flight
	logic  valid_s1;
	step_t step_s1;

	// result register
	logic       out_valid_q;
	logic [7:0] rd_q;
	logic       irq_q;
	view_t      view_q;

	// stage 1 moves on when the result register is free or being drained
	assign advance   = valid_s1 && (!out_valid_q || result.ready);
	assign bus.ready = !valid_s1 || advance;
	assign accept    = bus.valid && bus.ready;

	vdp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.op       (bus.op),
		.data     (bus.data),
		.vram_req (vram_req),
		.step     (step),
		.view     (view)
	);

	vdp_vram #(
		.DEPTH (VRAM_DEPTH),
		.WIDTH (8),
		.AW    (VRAM_AW)
	) u_vram (
		.clk   (clk),
		.we    (vram_req.we),
		.waddr (vram_req.waddr),
		.wdata (vram_req.wdata),
		.re    (vram_req.re),
		.raddr (vram_req.raddr),
		.rdata (vram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			step_s1 <= step;
		end
		if (advance) begin
			// the view is still this operation's post-state: the next one
			// only updates it at this same edge
			rd_q   <= step_s1.vram_rd ? vram_rdata : step_s1.rd_value;
			irq_q  <= step_s1.irq;
			view_q <= view;
		end
	end

	assign result.valid               = out_valid_q;
	assign result.read_data           = rd_q;
	assign result.irq_request         = irq_q;
	assign result.screen_mode         = view_q.mode;
	assign result.name_table_base     = view_q.name_base;
	assign result.color_table_base    = view_q.color_base;
	assign result.pattern_table_base  = view_q.pattern_base;
	assign result.sprite_attr_base    = view_q.sattr_base;
	assign result.sprite_pattern_base = view_q.spattern_base;
	assign result.fore_color          = view_q.colour[7:4];
	assign result.back_color          = view_q.colour[3:0];

endmodule

[rtl/vdp_vram.sv]
// vdp_vram: generic single-write, single-read synchronous ram, registered read
// no dependencies
module vdp_vram #(
	parameter int DEPTH = 16384,
	parameter int WIDTH = 8,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/vdp_ctrl.sv]
// vdp_ctrl: control latch, address counters, status byte, control registers
// and decoded mode/table bases; depends on vdp_pkg
module vdp_ctrl import vdp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      accept,
	input  logic [2:0] op,
	input  logic [7:0] data,
	output vram_req_t vram_req,
	output step_t     step,
	output view_t     view
);

	logic [7:0] regs_q [8];
	logic [7:0] regs_d [8];
	logic       idle_q, idle_d;
	logic [7:0] latched_q, latched_d;
	vaddr_t     wa_q, wa_d;
	vaddr_t     ra_q, ra_d;
	logic [7:0] status_q, status_d;
	view_t      view_q, view_d;

	logic [2:0] rsel;
	logic [7:0] rval;
	logic [4:0] msel;
	mode_t      mode_new;
	logic       reg_wr;
	logic [7:0] r0_v, r1_v;

	assign rsel = data[2:0];
	assign rval = (rsel == REG_SPATT) ? (latched_q & SPATT_MASK) : latched_q;
	assign reg_wr = accept && (op_t'(op) == OP_CTRL_WR) && !idle_q
		&& (cmd_t'(data[7:6]) == CMD_REG);
	assign r0_v = (rsel == REG_MODE0) ? rval : regs_q[0];
	assign r1_v = (rsel == REG_MODE1) ? rval : regs_q[1];
	assign msel = {r1_v[4:3], r0_v[3:1]};

	// unmatched select codes keep the current mode
	always_comb begin
		unique case (msel)
			SEL_TEXT: mode_new = MODE_TEXT;
			SEL_G1:   mode_new = MODE_G1;
			SEL_G2:   mode_new = MODE_G2;
			SEL_MC:   mode_new = MODE_MC;
			default:  mode_new = view_q.mode;
		endcase
	end

	always_comb begin
		regs_d    = regs_q;
		idle_d    = idle_q;
		latched_d = latched_q;
		wa_d      = wa_q;
		ra_d      = ra_q;
		status_d  = status_q;
		view_d    = view_q;
		vram_req  = '{we: 1'b0, re: 1'b0, waddr: wa_q, raddr: ra_q, wdata: data};
		step      = '{vram_rd: 1'b0, rd_value: 8'h00, irq: 1'b0};
		if (accept) begin
			case (op_t'(op))
				OP_DATA_WR: begin
					if (idle_q) begin
						vram_req.we = 1'b1;
						wa_d = wa_q + 1'b1;
					end
				end
				OP_CTRL_WR: begin
					if (idle_q) begin
						latched_d = data;
						idle_d    = 1'b0;
					end else begin
						idle_d = 1'b1;
						unique case (cmd_t'(data[7:6]))
							CMD_WADDR: wa_d = {data[5:0], latched_q};
							CMD_RADDR: ra_d = {data[5:0], latched_q};
							CMD_REG, CMD_NONE: ;
							default: ;
						endcase
					end
				end
				OP_DATA_RD: begin
					vram_req.re  = 1'b1;
					step.vram_rd = 1'b1;
					ra_d = ra_q + 1'b1;
				end
				OP_STATUS_RD: begin
					step.rd_value = status_q;
					status_d = status_q & STATUS_RD_KEEP;
					idle_d   = 1'b1;
				end
				OP_TICK: begin
					status_d = (status_q & TICK_KEEP) | FRAME_FLAG;
					step.irq = idle_q && regs_q[1][IRQ_EN_BIT];
				end
				default: ;
			endcase
		end
		if (reg_wr) begin
			regs_d[rsel] = rval;
			unique case (rsel)
				REG_MODE0, REG_MODE1: begin
					if (mode_new != view_q.mode) begin
						view_d.mode          = mode_new;
						view_d.name_base     = name_base_of(regs_q[2], mode_new);
						view_d.color_base    = color_base_of(regs_q[3], mode_new);
						view_d.pattern_base  = pattern_base_of(regs_q[4], mode_new);
						view_d.sattr_base    = sattr_base_of(regs_q[5], mode_new);
						view_d.spattern_base = spattern_base_of(regs_q[6]);
					end
				end
				REG_NAME:   view_d.name_base     = name_base_of(rval, view_q.mode);
				REG_COLOR:  view_d.color_base    = color_base_of(rval, view_q.mode);
				REG_PATT:   view_d.pattern_base  = pattern_base_of(rval, view_q.mode);
				REG_SATTR:  view_d.sattr_base    = sattr_base_of(rval, view_q.mode);
				REG_SPATT:  view_d.spattern_base = spattern_base_of(rval);
				REG_COLOUR: view_d.colour        = rval;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				regs_q[i] <= 8'h00;
			end
			regs_q[1] <= REG1_RESET;
			idle_q    <= 1'b1;
			latched_q <= 8'h00;
			wa_q      <= '0;
			ra_q      <= '0;
			status_q  <= STATUS_RESET;
			view_q    <= '{mode: MODE_TEXT, name_base: '0, color_base: '0,
				pattern_base: '0, sattr_base: '0, spattern_base: '0, colour: 8'h00};
		end else begin
			regs_q    <= regs_d;
			idle_q    <= idle_d;
			latched_q <= latched_d;
			wa_q      <= wa_d;
			ra_q      <= ra_d;
			status_q  <= status_d;
			view_q    <= view_d;
		end
	end

	assign view = view_q;

endmodule

[rtl/vdp_checker.sv]
// vdp_checker: port-level assertions for the video display processor port
// bound to video_display_processor_port_core; depends on nothing else
module vdp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       bus_ready,
	input logic       res_valid,
	input logic       res_ready,
	input logic [7:0] read_data,
	input logic       irq_request
);

	// reset leaves the result register empty
	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> !res_valid)
		else $error("result valid after a reset edge");

	// an empty result register never blocks the bus side
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> bus_ready)
		else $error("bus stalled with empty result register");

	// an interrupt only comes from a tick, which returns no read byte
	a_irq_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && irq_request |-> read_data == 8'h00)
		else $error("interrupt result carries read data");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(read_data)
		&& $stable(irq_request))
		else $error("stalled result changed");

endmodule

bind video_display_processor_port_core vdp_checker u_vdp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.bus_ready   (bus.ready),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.read_data   (result.read_data),
	.irq_request (result.irq_request)
);

[test/tb_video_display_processor_port_core.sv]
`timescale 1ns / 100ps
// tb_video_display_processor_port_core: self-checking bench for the VDP CPU port core
// drives bus transactions, predicts each result transaction in step and checks every field
// depends on vdp_pkg, vdp_if and video_display_processor_port_core
module tb_video_display_processor_port_core;
	import vdp_pkg::*;

	localparam int CLK_HALF     = 2;
	localparam int RESET_CYCLES = 4;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 16;
	localparam int PHASE_ITEMS  = 100;
	localparam int REPORT_MAX   = 10;
	localparam int BURST_MAX    = 10;

	// op codes past the frame tick; the port ignores them
	localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

	localparam vaddr_t ADDR_TOP = vaddr_t'(VRAM_DEPTH - 1);

	// everything one result transaction carries
	typedef struct packed {
		logic [7:0] read_data;
		logic       irq;
		mode_t      mode;
		vaddr_t     name_base;
		vaddr_t     color_base;
		vaddr_t     pattern_base;
		vaddr_t     sattr_base;
		vaddr_t     spattern_base;
		logic [3:0] fore;
		logic [3:0] back;
	} port_view_t;

	// one bus operation waiting to be driven, with the result it must produce
	typedef struct packed {
		logic [2:0] op;
		logic [7:0] data;
		port_view_t view;
	} bus_op_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	vdp_in_if  bus_if ();
	vdp_out_if res_if ();

	video_display_processor_port_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.bus    (bus_if),
		.result (res_if)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// shadow copy of the port state, advanced once per generated operation
	// ------------------------------------------------------------------
	logic [7:0] vram_shadow  [VRAM_DEPTH];
	bit         vram_written [VRAM_DEPTH];
	logic [7:0] regs_shadow  [8];
	logic       latch_empty  = 1'b1;
	logic [7:0] first_byte   = 8'h00;
	vaddr_t     wr_ptr       = '0;
	vaddr_t     rd_ptr       = '0;
	logic [7:0] status_shadow = STATUS_RESET;
	mode_t      mode_shadow  = MODE_TEXT;
	vaddr_t     base_shadow  [5];
	logic [7:0] colour_shadow = 8'h00;

	// addresses that hold a written byte, used to aim read bursts
	vaddr_t     written_list [$];

	bus_op_t    op_queue     [$];
	port_view_t due_results  [$];
	bus_op_t    next_op;
	port_view_t flight_view;
	port_view_t want_view;

	int items_made  = 0;
	int fault_count = 0;
	int cycle_count = 0;
	int gap_pct     = 0;
	int stall_pct   = 0;

	// table base: masked register value shifted into place, cut to the VRAM address width
	function automatic vaddr_t table_base(logic [7:0] v, logic [7:0] keep, int shift);
		logic [21:0] wide;
		wide = {14'b0, v & keep} << shift;
		return wide[VRAM_AW-1:0];
	endfunction

	// mode select from registers 0 and 1; codes with no meaning keep the mode,
	// and the bases are only rebuilt when the mode actually changes
	task automatic decode_mode(input logic [7:0] r0, input logic [7:0] r1);
		logic [4:0] sel;
		mode_t      m;
		sel = {r1[4:3], r0[3:1]};
		m   = mode_shadow;
		case (sel)
			SEL_TEXT: m = MODE_TEXT;
			SEL_G1:   m = MODE_G1;
			SEL_G2:   m = MODE_G2;
			SEL_MC:   m = MODE_MC;
			default:  m = mode_shadow;
		endcase
		if (m != mode_shadow) begin
			base_shadow[0] = table_base(regs_shadow[REG_NAME], R2_MASK[m], 10);
			base_shadow[1] = table_base(regs_shadow[REG_COLOR], R3_MASK[m], 6);
			base_shadow[2] = table_base(regs_shadow[REG_PATT], R4_MASK[m], 11);
			base_shadow[3] = table_base(regs_shadow[REG_SATTR], R5_MASK[m], 7);
			base_shadow[4] = table_base(regs_shadow[REG_SPATT], SPATT_MASK, 11);
			mode_shadow = m;
		end
	endtask

	task automatic load_register(input logic [2:0] idx, input logic [7:0] value);
		logic [7:0] v;
		v = value;
		case (idx)
			REG_MODE0: decode_mode(v, regs_shadow[REG_MODE1]);
			REG_MODE1: decode_mode(regs_shadow[REG_MODE0], v);
			REG_NAME:  base_shadow[0] = table_base(v, R2_MASK[mode_shadow], 10);
			REG_COLOR: base_shadow[1] = table_base(v, R3_MASK[mode_shadow], 6);
			REG_PATT:  base_shadow[2] = table_base(v, R4_MASK[mode_shadow], 11);
			REG_SATTR: base_shadow[3] = table_base(v, R5_MASK[mode_shadow], 7);
			REG_SPATT: begin
				v = v & SPATT_MASK;
				base_shadow[4] = table_base(v, SPATT_MASK, 11);
			end
			default:   colour_shadow = v;
		endcase
		regs_shadow[idx] = v;
	endtask

	// advance the shadow by one bus operation and give the result it must produce
	task automatic predict_port_step(input logic [2:0] op, input logic [7:0] d,
			output port_view_t view);
		logic [7:0] rd;
		logic       irq;
		rd  = 8'h00;
		irq = 1'b0;
		case (op)
			OP_DATA_WR: begin
				// ignored while the control latch holds a first byte
				if (latch_empty) begin
					vram_shadow[wr_ptr]  = d;
					vram_written[wr_ptr] = 1'b1;
					wr_ptr = wr_ptr + 1'b1;
				end
			end
			OP_CTRL_WR: begin
				if (latch_empty) begin
					first_byte  = d;
					latch_empty = 1'b0;
				end else begin
					latch_empty = 1'b1;
					case (cmd_t'(d[7:6]))
						CMD_REG:   load_register(d[2:0], first_byte);
						CMD_WADDR: wr_ptr = {d[5:0], first_byte};
						CMD_RADDR: rd_ptr = {d[5:0], first_byte};
						default:   ;  // only re-arms the latch
					endcase
				end
			end
			OP_DATA_RD: begin
				// proceeds with the latch half full and leaves it as it is
				rd     = vram_shadow[rd_ptr];
				rd_ptr = rd_ptr + 1'b1;
			end
			OP_STATUS_RD: begin
				rd            = status_shadow;
				status_shadow = status_shadow & STATUS_RD_KEEP;
				latch_empty   = 1'b1;
			end
			OP_TICK: begin
				status_shadow = (status_shadow & TICK_KEEP) | FRAME_FLAG;
				irq = latch_empty & regs_shadow[REG_MODE1][IRQ_EN_BIT];
			end
			default: ;
		endcase
		view.read_data     = rd;
		view.irq           = irq;
		view.mode          = mode_shadow;
		view.name_base     = base_shadow[0];
		view.color_base    = base_shadow[1];
		view.pattern_base  = base_shadow[2];
		view.sattr_base    = base_shadow[3];
		view.spattern_base = base_shadow[4];
		view.fore          = colour_shadow[7:4];
		view.back          = colour_shadow[3:0];
	endtask

	// queue one bus operation; a data read aimed at a never-written entry turns
	// into an ignored op code so no unwritten VRAM byte is ever read
	task automatic issue(input logic [2:0] op, input logic [7:0] d);
		bus_op_t item;
		item.op   = (op == OP_DATA_RD && !vram_written[rd_ptr]) ? OP_SPARE_FIRST : op;
		item.data = d;
		if (item.op == OP_DATA_WR && latch_empty)
			written_list.push_back(wr_ptr);
		predict_port_step(item.op, item.data, item.view);
		op_queue.push_back(item);
		items_made++;
	endtask

	task automatic ctrl_pair(input logic [7:0] lo, input logic [7:0] hi);
		issue(OP_CTRL_WR, lo);
		issue(OP_CTRL_WR, hi);
	endtask

	// a status read re-arms a half-full latch before a well-formed sequence
	task automatic arm_latch();
		if (!latch_empty)
			issue(OP_STATUS_RD, 8'($urandom()));
	endtask

	task automatic report_fault(input string what, input logic [31:0] want,
			input logic [31:0] got);
		fault_count++;
		if (fault_count <= REPORT_MAX)
			$display("[%0t] %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
	endtask

	task automatic check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got)
			report_fault(what, want, got);
	endtask

	// ------------------------------------------------------------------
	// driver: presents queued operations, holds each one until its transaction
	// completes, and only then hands its result to the checker
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus_if.valid <= 1'b0;
			bus_if.op    <= '0;
			bus_if.data  <= '0;
		end else if (!bus_if.valid || bus_if.ready) begin
			if (bus_if.valid)
				due_results.push_back(flight_view);
			if (op_queue.size() != 0 && $urandom_range(99) >= gap_pct) begin
				next_op      = op_queue.pop_front();
				flight_view  = next_op.view;
				bus_if.valid <= 1'b1;
				bus_if.op    <= next_op.op;
				bus_if.data  <= next_op.data;
			end else begin
				bus_if.valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// monitor: every completed result transaction is matched against the
	// oldest outstanding prediction; ready is thrown around at random
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else begin
			if (res_if.valid && res_if.ready) begin
				if (due_results.size() == 0) begin
					report_fault("result with nothing outstanding", 0, res_if.read_data);
				end else begin
					want_view = due_results.pop_front();
					check_field("read_data", want_view.read_data, res_if.read_data);
					check_field("irq_request", want_view.irq, res_if.irq_request);
					check_field("screen_mode", want_view.mode, res_if.screen_mode);
					check_field("name_table_base", want_view.name_base,
						res_if.name_table_base);
					check_field("color_table_base", want_view.color_base,
						res_if.color_table_base);
					check_field("pattern_table_base", want_view.pattern_base,
						res_if.pattern_table_base);
					check_field("sprite_attr_base", want_view.sattr_base,
						res_if.sprite_attr_base);
					check_field("sprite_pattern_base", want_view.spattern_base,
						res_if.sprite_pattern_base);
					check_field("fore_color", want_view.fore, res_if.fore_color);
					check_field("back_color", want_view.back, res_if.back_color);
				end
			end
			res_if.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// watchdog against a hung handshake
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** video_display_processor_port_core: FAILED **");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// stimulus: directed corner cases, then four phases of random sequences,
	// each with its own bus gap and result stall rates, then drain and verdict
	// ------------------------------------------------------------------
	initial begin
		int         roll;
		int         target;
		int         burst;
		vaddr_t     addr;
		logic [2:0] idx;
		logic [7:0] value;

		for (int i = 0; i < 8; i++)
			regs_shadow[i] = 8'h00;
		regs_shadow[REG_MODE1] = REG1_RESET;
		for (int i = 0; i < 5; i++)
			base_shadow[i] = '0;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// status after reset, then with the frame and bit 5 flags cleared
		issue(OP_STATUS_RD, 8'hFF);
		issue(OP_STATUS_RD, 8'h00);
		// interrupt enable with graphics one selected, then a tick that fires
		ctrl_pair(8'h20, {CMD_REG, 3'($urandom()), REG_MODE1});
		issue(OP_TICK, 8'hFF);
		// a tick while the latch is half full must not raise the interrupt,
		// and a second byte with both top bits set only re-arms the latch
		issue(OP_CTRL_WR, 8'hA5);
		issue(OP_TICK, 8'h00);
		issue(OP_CTRL_WR, {CMD_NONE, 6'h3F});
		// write address at the top of VRAM, the first of two writes wraps it to zero
		ctrl_pair(8'hFF, {CMD_WADDR, 6'h3F});
		issue(OP_DATA_WR, 8'hFF);
		issue(OP_DATA_WR, 8'h00);
		// half-full latch: data write dropped, data read still goes ahead
		issue(OP_CTRL_WR, 8'hFF);
		issue(OP_DATA_WR, 8'h55);
		issue(OP_DATA_RD, 8'hFF);
		issue(OP_CTRL_WR, {CMD_RADDR, 6'h3F});
		// read address wraps from the top entry back to zero
		issue(OP_DATA_RD, 8'h00);
		issue(OP_DATA_RD, 8'hFF);
		// colours and name base at their extremes, then switch to graphics two
		ctrl_pair(8'hFF, {CMD_REG, 3'($urandom()), REG_COLOUR});
		ctrl_pair(8'hFF, {CMD_REG, 3'($urandom()), REG_NAME});
		ctrl_pair(8'h02, {CMD_REG, 3'($urandom()), REG_MODE0});
		// unused op codes
		issue(OP_SPARE_FIRST, 8'hFF);
		issue(OP_SPARE_LAST, 8'h00);

		for (int ph = 0; ph < 4; ph++) begin
			while (op_queue.size() != 0)
				@(posedge clk);
			@(negedge clk);
			case (ph)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 46; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 46; end
				default: begin gap_pct = 26; stall_pct = 26; end
			endcase
			target = items_made + PHASE_ITEMS;
			while (items_made < target) begin
				roll = $urandom_range(99);
				if (roll < 25) begin
					// write burst, now and then straddling the top of VRAM
					arm_latch();
					if ($urandom_range(7) == 0)
						addr = ADDR_TOP - vaddr_t'($urandom_range(3));
					else
						addr = vaddr_t'($urandom());
					ctrl_pair(addr[7:0], {CMD_WADDR, addr[13:8]});
					burst = $urandom_range(BURST_MAX, 1);
					repeat (burst)
						issue(OP_DATA_WR, 8'($urandom()));
				end else if (roll < 45) begin
					// read burst starting on a written entry
					if (written_list.size() != 0) begin
						arm_latch();
						addr = written_list[$urandom_range(written_list.size() - 1)];
						ctrl_pair(addr[7:0], {CMD_RADDR, addr[13:8]});
						burst = $urandom_range(BURST_MAX, 1);
						repeat (burst)
							if (vram_written[rd_ptr])
								issue(OP_DATA_RD, 8'($urandom()));
					end
				end else if (roll < 65) begin
					// register write; mode registers often steered onto real modes
					arm_latch();
					idx   = 3'($urandom());
					value = 8'($urandom());
					if ($urandom_range(1)) begin
						if (idx == REG_MODE0)
							value[3:1] = {2'b00, 1'($urandom())};
						else if (idx == REG_MODE1)
							value[4:3] = 2'($urandom());
					end
					ctrl_pair(value, {CMD_REG, 3'($urandom()), idx});
				end else if (roll < 75) begin
					issue($urandom_range(1) ? OP_TICK : OP_STATUS_RD, 8'($urandom()));
				end else if (roll < 85) begin
					// second byte with both top bits set
					arm_latch();
					ctrl_pair(8'($urandom()), {CMD_NONE, 6'($urandom())});
				end else begin
					// raw noise, including stray control bytes and unused codes
					issue(3'($urandom()), 8'($urandom()));
				end
			end
		end

		while (op_queue.size() != 0 || bus_if.valid || due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fault_count == 0 && due_results.size() == 0)
			$display("** video_display_processor_port_core: PASSED **");
		else
			$display("** video_display_processor_port_core: FAILED **");
		$finish;
	end

endmodule
